>>> rtl/b32e_pkg.sv
// Package for the Base32 stream encoder: codes, characters, job type and alphabet.
// Depends on nothing; every other file of the encoder but b32e_if imports it.
package b32e_pkg;

  localparam int LINE_LENGTH_DEF = 76;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic       OP_DATA  = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] NL_CHAR  = 8'h0A;

  // One unit of output work: a 40-bit group (possibly zero-filled) and its framing.
  typedef struct packed {
    logic [39:0] bits;
    logic [3:0]  keep;
    logic        has_group;
    logic        flush;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Alphabet A-Z for 0..25, then 2-7 for 26..31.
  function automatic logic [7:0] symbol_char(input logic [4:0] idx);
    logic [7:0] c;
    if (idx < 5'd26) begin
      c = 8'h41 + {3'b000, idx};
    end else begin
      c = 8'h18 + {3'b000, idx};
    end
    return c;
  endfunction

endpackage

>>> rtl/b32e_if.sv
// Stream interfaces of the Base32 encoder: byte input and character output.
// Depends on nothing.
interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> rtl/base32_stream_encoder_unit.sv
// Top level of the Base32 stream encoder: front end, job queue and back end.
// Depends on b32e_pkg, b32e_if, b32e_front, b32e_queue and b32e_back.
//
// Bytes enter with op = 0 and an end marker with op = 1; characters leave one
// per transfer, with last set on the final character caused by an input item.
// Bytes that only fill the open group are taken every cycle while the queue is not
// full. A byte that completes a group, or an end marker, becomes a job in a
// two-entry queue; the back end loads a job and then emits its characters
// (8 symbols plus up to two newlines) one after another. The character
// sequencer, which emits a single character per cycle while the output is ready,
// sets the throughput; input stalls only while the queue is full.
module base32_stream_encoder_unit #(
  parameter int LINE_LENGTH = b32e_pkg::LINE_LENGTH_DEF
) (
  input logic         clk,
  input logic         rst,
  b32e_in_if.sink     data_in,
  b32e_out_if.source  char_out
);
  import b32e_pkg::*;

  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  b32e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .data_in  (data_in),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  b32e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  b32e_back #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .char_out (char_out)
  );

endmodule

>>> rtl/b32e_front.sv
// Front end: takes bytes and end markers, gathers groups of five and issues jobs.
// Depends on b32e_pkg and b32e_in_if.
module b32e_front (
  input  logic              clk,
  input  logic              rst,
  b32e_in_if.sink           data_in,
  input  b32e_pkg::q_stat_t q_stat,
  output logic              push,
  output b32e_pkg::job_t    push_job
);
  import b32e_pkg::*;

  logic [31:0] group_bytes;
  logic [2:0]  bytes_held;
  logic        accept;

  assign data_in.ready = !q_stat.full;
  assign accept        = data_in.valid && data_in.ready;
  assign push          = accept && (data_in.op == OP_FLUSH || bytes_held == 3'd4);

  always_comb begin
    push_job           = '0;
    push_job.flush     = (data_in.op == OP_FLUSH);
    push_job.has_group = 1'b1;
    if (data_in.op == OP_DATA) begin
      push_job.bits = {group_bytes, data_in.data_byte};
      push_job.keep = 4'd8;
    end else begin
      case (bytes_held)
        3'd1: begin
          push_job.bits = {group_bytes[7:0], 32'h0};
          push_job.keep = 4'd2;
        end
        3'd2: begin
          push_job.bits = {group_bytes[15:0], 24'h0};
          push_job.keep = 4'd4;
        end
        3'd3: begin
          push_job.bits = {group_bytes[23:0], 16'h0};
          push_job.keep = 4'd5;
        end
        3'd4: begin
          push_job.bits = {group_bytes, 8'h0};
          push_job.keep = 4'd7;
        end
        default: begin
          push_job.bits      = '0;
          push_job.keep      = 4'd0;
          push_job.has_group = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= '0;
      bytes_held  <= '0;
    end else if (accept) begin
      if (push) begin
        group_bytes <= '0;
        bytes_held  <= '0;
      end else begin
        group_bytes <= {group_bytes[23:0], data_in.data_byte};
        bytes_held  <= bytes_held + 3'd1;
      end
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst) bytes_held <= 3'd4)
    else $error("open group holds more than four bytes");

endmodule

>>> rtl/b32e_queue.sv
// Short job queue between the front end and the character sequencer.
// Depends on b32e_pkg.
module b32e_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b32e_pkg::job_t     push_job,
  input  logic               pop,
  output b32e_pkg::job_t     head_job,
  output b32e_pkg::q_stat_t  q_stat
);
  import b32e_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_stat.full  = (count == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full || pop)
    else $error("job written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("job taken from an empty queue");

endmodule

>>> rtl/b32e_back.sv
// Back end: turns queued jobs into Base32 symbols, pads, line and final newlines.
// Depends on b32e_pkg and b32e_out_if.
module b32e_back #(
  parameter int LINE_LENGTH = b32e_pkg::LINE_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  b32e_pkg::job_t    head_job,
  input  b32e_pkg::q_stat_t q_stat,
  output logic              pop,
  b32e_out_if.source        char_out
);
  import b32e_pkg::*;

  localparam int LcW = $clog2(LINE_LENGTH + 4);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SYM  = 4'b0010,
    S_LNL  = 4'b0100,
    S_FNL  = 4'b1000
  } state_t;

  state_t         state;
  job_t           job;
  logic [2:0]     k;
  logic [LcW-1:0] line_count;
  logic [LcW-1:0] lc_sum;
  logic [LcW-1:0] lc_wrap;
  logic           out_v;
  logic [7:0]     out_char;
  logic           out_last;
  logic           emit_en;

  assign char_out.valid    = out_v;
  assign char_out.out_char = out_char;
  assign char_out.last     = out_last;

  assign emit_en = !out_v || char_out.ready;
  assign pop     = (state == S_IDLE) && emit_en && !q_stat.empty;

  // Count after a half group of four; it stays below the line length plus four.
  assign lc_sum  = line_count + LcW'(4);
  assign lc_wrap = (lc_sum >= LcW'(LINE_LENGTH)) ? lc_sum - LcW'(LINE_LENGTH) : lc_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_v      <= 1'b0;
      line_count <= '0;
      k          <= '0;
    end else if (emit_en) begin
      out_v    <= 1'b0;
      out_last <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job   <= head_job;
            k     <= '0;
            state <= head_job.has_group ? S_SYM : S_FNL;
          end
        end
        S_SYM: begin
          out_v    <= 1'b1;
          out_char <= ({1'b0, k} < job.keep) ? symbol_char(job.bits[39:35]) : PAD_CHAR;
          job.bits <= {job.bits[34:0], 5'b00000};
          if (k[1:0] == 2'd3) begin
            line_count <= lc_wrap;
            if (lc_wrap == '0) begin
              state <= S_LNL;
            end else if (k == 3'd7) begin
              out_last <= !job.flush;
              state    <= job.flush ? S_FNL : S_IDLE;
            end else begin
              k <= k + 3'd1;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_LNL: begin
          out_v    <= 1'b1;
          out_char <= NL_CHAR;
          if (k == 3'd7) begin
            out_last <= !job.flush;
            state    <= job.flush ? S_FNL : S_IDLE;
          end else begin
            k     <= k + 3'd1;
            state <= S_SYM;
          end
        end
        S_FNL: begin
          out_v      <= 1'b1;
          out_char   <= NL_CHAR;
          out_last   <= 1'b1;
          line_count <= '0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_line_range: assert property (@(posedge clk) disable iff (rst)
      line_count < LcW'(LINE_LENGTH))
    else $error("line count out of range");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
      (state == S_FNL && emit_en) |=> (line_count == '0 && out_last && out_v))
    else $error("final newline did not end the stream");

endmodule
